@@ rtl/core/ahcf_pkg.sv @@
// ----------------------------------------------------------------------------
// ahcf_pkg
// Shared types and constants of the anchor hit conflict filter.
// ----------------------------------------------------------------------------
package ahcf_pkg;

	localparam int FIELD_W   = 16;  // width of start and length fields on the ports
	localparam int LIMIT_W   = 16;  // width of the overlap limit registers
	localparam int VERDICT_W = 2;
	localparam int CFG_IDX_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LIMIT   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PARTIAL_LIMIT = 8'd1;

	// verdict codes
	localparam logic [VERDICT_W-1:0] VERD_REJECT = 2'd0;
	localparam logic [VERDICT_W-1:0] VERD_DECENT = 2'd1;
	localparam logic [VERDICT_W-1:0] VERD_STORED = 2'd2;
	localparam logic [VERDICT_W-1:0] VERD_FULL   = 2'd3;

	// per-cell judgment of the current hit against the cell's anchor
	typedef struct packed {
		logic bad;
		logic decent;
	} cell_flags_t;

endpackage

@@ rtl/core/ahcf_if.sv @@
// ----------------------------------------------------------------------------
// ahcf_if
// Valid/ready channel interfaces: hit input, verdict output, register writes.
// ----------------------------------------------------------------------------
interface ahcf_hit_if;
	logic                         valid;
	logic                         ready;
	logic [ahcf_pkg::FIELD_W-1:0] start_a;
	logic [ahcf_pkg::FIELD_W-1:0] start_b;
	logic [ahcf_pkg::FIELD_W-1:0] hit_length;
	logic                         first_of_set;

	modport source (output valid, start_a, start_b, hit_length, first_of_set, input ready);
	modport sink (input valid, start_a, start_b, hit_length, first_of_set, output ready);
endinterface

interface ahcf_verdict_if;
	logic                           valid;
	logic                           ready;
	logic [ahcf_pkg::VERDICT_W-1:0] verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

interface ahcf_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ahcf_pkg::CFG_IDX_W-1:0] index;
	logic [ahcf_pkg::LIMIT_W-1:0]   wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

@@ rtl/core/ahcf_cell.sv @@
// ----------------------------------------------------------------------------
// ahcf_cell
// One stored anchor: shifts in from its neighbor on a store, and judges the
// current hit against its anchor, registering the result flags.
// ----------------------------------------------------------------------------
module ahcf_cell #(
	parameter int POS_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic                          cmp_en,
	input  logic                          active,
	input  logic [POS_WIDTH-1:0]          prev_a,
	input  logic [POS_WIDTH-1:0]          prev_b,
	input  logic [POS_WIDTH-1:0]          prev_len,
	input  logic [POS_WIDTH-1:0]          hit_a,
	input  logic [POS_WIDTH-1:0]          hit_b,
	input  logic [POS_WIDTH-1:0]          hit_len,
	input  logic [ahcf_pkg::LIMIT_W-1:0]  total_limit,
	input  logic [ahcf_pkg::LIMIT_W-1:0]  partial_limit,
	output logic [POS_WIDTH-1:0]          anc_a,
	output logic [POS_WIDTH-1:0]          anc_b,
	output logic [POS_WIDTH-1:0]          anc_len,
	output ahcf_pkg::cell_flags_t         flags
);
	import ahcf_pkg::*;

	localparam int EW = POS_WIDTH + 1;          // end positions and sums
	localparam int DW = EW + LIMIT_W;           // common width for limit compare

	logic [POS_WIDTH-1:0] a_q, b_q, len_q;
	cell_flags_t          flags_q;

	logic [EW-1:0] ha, hb, sa, sb, hae, hbe, sae, sbe;
	logic [EW-1:0] p_sum, q_sum, diag_d;
	logic [DW-1:0] dist_x, tot_x, par_x;
	logic          crosses, contained, head_hs, head_sh, conf, over_tot, over_par;

	// advance the chain on a store
	always_ff @(posedge clk) begin
		if (shift_en) begin
			a_q   <= prev_a;
			b_q   <= prev_b;
			len_q <= prev_len;
		end
	end

	always_comb begin
		ha  = EW'(hit_a);
		hb  = EW'(hit_b);
		sa  = EW'(a_q);
		sb  = EW'(b_q);
		hae = ha + EW'(hit_len);
		hbe = hb + EW'(hit_len);
		sae = sa + EW'(len_q);
		sbe = sb + EW'(len_q);

		crosses = (ha < sa && hb > sb && hae < sae) || (ha > sa && hb < sb && hbe < sbe);
		contained = (ha >= sa && hae <= sae) || (hb >= sb && hbe <= sbe);
		// head of hit over tail of anchor, and the other way round
		head_hs = (ha >= sa && hae > sae && sae > ha) || (hb >= sb && hbe > sbe && sbe > hb);
		head_sh = (sa >= ha && sae > hae && hae > sa) || (sb >= hb && sbe > hbe && hbe > sb);

		// |(sa - sb) - (ha - hb)| = |(sa + hb) - (sb + ha)|
		p_sum  = sa + hb;
		q_sum  = sb + ha;
		diag_d = (p_sum > q_sum) ? (p_sum - q_sum) : (q_sum - p_sum);

		dist_x   = DW'(diag_d);
		tot_x    = DW'(total_limit);
		par_x    = DW'(partial_limit);
		over_tot = dist_x > tot_x;
		over_par = dist_x > par_x;
		conf     = crosses || contained;
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			flags_q.bad    <= active && ((conf && over_tot) ||
				(!conf && (head_hs || head_sh) && over_par));
			flags_q.decent <= active && conf && !over_tot;
		end
	end

	assign anc_a   = a_q;
	assign anc_b   = b_q;
	assign anc_len = len_q;
	assign flags   = flags_q;

endmodule

@@ rtl/core/anchor_hit_conflict_filter.sv @@
// ----------------------------------------------------------------------------
// anchor_hit_conflict_filter
// Judges anchor hits against a chain of accepted anchors and stores the
// hits that conflict with nothing while there is room.
// ----------------------------------------------------------------------------
//
//   port      dir    payload                                        handshake
//   --------  -----  ---------------------------------------------  -----------
//   hits      sink   start_a, start_b, hit_length, first_of_set     valid/ready
//   verdicts  source verdict                                        valid/ready
//   cfg       sink   index, wdata (total / partial overlap limit)   valid/ready
//
// From acceptance to a valid verdict, each hit passes a compare in every cell
// at once (flags registered in the cell), then an OR-reduce and decide step.
// The decide step also accepts the next hit, so a new hit can enter while the
// last is decided, but not during its registered per-cell compare.
// Reset empties the store at once (count zero); anchor cells are not cleared.
// A verdict that is not taken holds the decide step, and with it the input.
// Register writes are always ready.
// ----------------------------------------------------------------------------
module anchor_hit_conflict_filter #(
	parameter int MAX_ANCHORS = 64,
	parameter int POS_WIDTH   = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	ahcf_hit_if.sink       hits,
	ahcf_verdict_if.source verdicts,
	ahcf_cfg_if.sink       cfg
);
	import ahcf_pkg::*;

	localparam int CNT_W = $clog2(MAX_ANCHORS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ANCHORS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_DEC  = 2'd2;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       count_q;
	logic [LIMIT_W-1:0]     total_limit_q, partial_limit_q;
	logic [POS_WIDTH-1:0]   hit_a_q, hit_b_q, hit_len_q;
	logic                   first_q;
	logic                   out_valid_q;
	logic [VERDICT_W-1:0]   verdict_q;

	logic                   hit_acc, can_dec, do_dec, store;
	logic                   any_bad, any_decent;
	logic [CNT_W-1:0]       base_cnt;
	logic [VERDICT_W-1:0]   dec_verdict;

	logic [MAX_ANCHORS-1:0] bad_vec, decent_vec, active_vec;
	logic [POS_WIDTH-1:0]   chain_a   [MAX_ANCHORS+1];
	logic [POS_WIDTH-1:0]   chain_b   [MAX_ANCHORS+1];
	logic [POS_WIDTH-1:0]   chain_len [MAX_ANCHORS+1];
	cell_flags_t            cell_flags [MAX_ANCHORS];

	// register writes: unknown indexes drop silently
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_limit_q   <= '0;
			partial_limit_q <= '0;
		end else if (cfg.valid) begin
			if (cfg.index == REG_TOTAL_LIMIT) begin
				total_limit_q <= cfg.wdata;
			end
			if (cfg.index == REG_PARTIAL_LIMIT) begin
				partial_limit_q <= cfg.wdata;
			end
		end
	end

	// decide only when the output register is free or being drained
	assign can_dec    = !out_valid_q || verdicts.ready;
	assign do_dec     = (state_q == ST_DEC) && can_dec;
	assign hits.ready = (state_q == ST_IDLE) || do_dec;
	assign hit_acc    = hits.valid && hits.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (hit_acc) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (do_dec) begin
						state_q <= hit_acc ? ST_CMP : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the hit under judgment; positions are taken in POS_WIDTH bits
	always_ff @(posedge clk) begin
		if (hit_acc) begin
			hit_a_q   <= POS_WIDTH'(hits.start_a);
			hit_b_q   <= POS_WIDTH'(hits.start_b);
			hit_len_q <= POS_WIDTH'(hits.hit_length);
			first_q   <= hits.first_of_set;
		end
	end

	// the chain: cell 0 takes the new hit, every cell passes to the next
	assign chain_a[0]   = hit_a_q;
	assign chain_b[0]   = hit_b_q;
	assign chain_len[0] = hit_len_q;

	for (genvar i = 0; i < MAX_ANCHORS; i++) begin : g_cell
		// a start of set empties the store before this hit is judged
		assign active_vec[i] = !first_q && (CNT_W'(i) < count_q);

		ahcf_cell #(
			.POS_WIDTH (POS_WIDTH)
		) u_cell (
			.clk           (clk),
			.shift_en      (store),
			.cmp_en        (state_q == ST_CMP),
			.active        (active_vec[i]),
			.prev_a        (chain_a[i]),
			.prev_b        (chain_b[i]),
			.prev_len      (chain_len[i]),
			.hit_a         (hit_a_q),
			.hit_b         (hit_b_q),
			.hit_len       (hit_len_q),
			.total_limit   (total_limit_q),
			.partial_limit (partial_limit_q),
			.anc_a         (chain_a[i+1]),
			.anc_b         (chain_b[i+1]),
			.anc_len       (chain_len[i+1]),
			.flags         (cell_flags[i])
		);

		assign bad_vec[i]    = cell_flags[i].bad;
		assign decent_vec[i] = cell_flags[i].decent;
	end

	// rejection wins over decent; otherwise store while there is room
	always_comb begin
		any_bad    = |bad_vec;
		any_decent = |decent_vec;
		base_cnt   = first_q ? '0 : count_q;
		store      = 1'b0;
		if (any_bad) begin
			dec_verdict = VERD_REJECT;
		end else if (any_decent) begin
			dec_verdict = VERD_DECENT;
		end else if (base_cnt < CNT_MAX) begin
			dec_verdict = VERD_STORED;
			store       = do_dec;
		end else begin
			dec_verdict = VERD_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_dec) begin
			count_q <= base_cnt + CNT_W'(store);
		end
	end

	// output register: load on decide, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_dec) begin
			out_valid_q <= 1'b1;
		end else if (verdicts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_dec) begin
			verdict_q <= dec_verdict;
		end
	end

	assign verdicts.valid   = out_valid_q;
	assign verdicts.verdict = verdict_q;

	// ---------------------------------------------------------------- checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("anchor count beyond capacity");

	a_cmp_to_dec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |=> state_q == ST_DEC)
		else $error("compare step not followed by decide");

	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		store |=> count_q == $past(base_cnt) + CNT_W'(1))
		else $error("store did not advance the count");

	a_full_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		do_dec && dec_verdict == VERD_FULL |-> base_cnt == CNT_MAX)
		else $error("full verdict with room in the store");

endmodule
